>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define AB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/abst_pkg.sv
package abst_pkg;

    localparam int unsigned SEQ_W = 64;

    typedef logic [1:0]       slot_t;
    typedef logic [1:0]       trial_t;
    typedef logic [1:0]       action_t;
    typedef logic [3:0]       fidx_t;
    typedef logic [SEQ_W-1:0] seq_t;

    localparam slot_t SLOT_NONE = 2'd0;
    localparam slot_t SLOT_A    = 2'd1;
    localparam slot_t SLOT_B    = 2'd2;

    localparam trial_t TRIAL_NONE    = 2'd0;
    localparam trial_t TRIAL_PENDING = 2'd1;
    localparam trial_t TRIAL_STARTED = 2'd2;

    localparam action_t ACT_ACTIVE   = 2'd0;
    localparam action_t ACT_PREVIOUS = 2'd1;
    localparam action_t ACT_TRIAL    = 2'd2;
    localparam action_t ACT_RECOVERY = 2'd3;

    typedef enum logic [2:0] {
        OP_BOOT    = 3'd0,
        OP_START   = 3'd1,
        OP_RETRY   = 3'd2,
        OP_DISCARD = 3'd3,
        OP_CONFIRM = 3'd4,
        OP_RAISE   = 3'd5,
        OP_LOAD    = 3'd6
    } op_t;

    // Journal field selectors for the load command
    localparam fidx_t FLD_ACTIVE     = 4'd0;
    localparam fidx_t FLD_PREVIOUS   = 4'd1;
    localparam fidx_t FLD_PENDING    = 4'd2;
    localparam fidx_t FLD_TRIAL      = 4'd3;
    localparam fidx_t FLD_DOWNGRADE  = 4'd4;
    localparam fidx_t FLD_GENERATION = 4'd5;
    localparam fidx_t FLD_INSTALLED  = 4'd6;
    localparam fidx_t FLD_PREV_SEQ   = 4'd7;
    localparam fidx_t FLD_CANDIDATE  = 4'd8;

    typedef struct packed {
        op_t   opcode;
        logic  rescue_held;
        logic  pending_verified;
        slot_t live_slot;
        seq_t  live_seq;
        fidx_t field_index;
        seq_t  field_value;
    } cmd_t;

    typedef struct packed {
        logic    ok;
        action_t boot_action;
        slot_t   boot_slot;
        logic    journal_consistent;
        slot_t   active_now;
        slot_t   pending_now;
        trial_t  trial_now;
        logic    downgrade_now;
        seq_t    generation_now;
        seq_t    floor_now;
    } res_t;

endpackage

>>> rtl/abst_if.sv
interface abst_cmd_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           opcode;
    logic                 rescue_held;
    logic                 pending_verified;
    abst_pkg::slot_t      live_slot;
    abst_pkg::seq_t       live_seq;
    abst_pkg::fidx_t      field_index;
    abst_pkg::seq_t       field_value;

    modport source (
        output valid, opcode, rescue_held, pending_verified, live_slot,
               live_seq, field_index, field_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, rescue_held, pending_verified, live_slot,
               live_seq, field_index, field_value,
        output ready
    );
endinterface

interface abst_res_if;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    abst_pkg::action_t    boot_action;
    abst_pkg::slot_t      boot_slot;
    logic                 journal_consistent;
    abst_pkg::slot_t      active_now;
    abst_pkg::slot_t      pending_now;
    abst_pkg::trial_t     trial_now;
    logic                 downgrade_now;
    abst_pkg::seq_t       generation_now;
    abst_pkg::seq_t       floor_now;

    modport source (
        output valid, ok, boot_action, boot_slot, journal_consistent, active_now,
               pending_now, trial_now, downgrade_now, generation_now, floor_now,
        input  ready
    );
    modport sink (
        input  valid, ok, boot_action, boot_slot, journal_consistent, active_now,
               pending_now, trial_now, downgrade_now, generation_now, floor_now,
        output ready
    );
endinterface

interface abst_cfg_if;
    logic           valid;
    logic           ready;
    abst_pkg::seq_t data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

>>> rtl/abst_journal.sv
`include "assert_macros.svh"

// Slot journal registers and the combinational command update.
module abst_journal (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  abst_pkg::cmd_t cmd,
    input  abst_pkg::seq_t dev_seq,
    output abst_pkg::res_t res
);

    abst_pkg::slot_t  active_reg,   active_next;
    abst_pkg::slot_t  prev_reg,     prev_next;
    abst_pkg::slot_t  pend_reg,     pend_next;
    abst_pkg::trial_t trial_reg,    trial_next;
    logic             dg_reg,       dg_next;
    abst_pkg::seq_t   gen_reg,      gen_next;
    abst_pkg::seq_t   inst_reg,     inst_next;
    abst_pkg::seq_t   prev_seq_reg, prev_seq_next;
    abst_pkg::seq_t   cand_reg,     cand_next;

    logic can_mut;
    logic started_ok;
    logic dg_cond;
    logic slot_run_ok;

    assign can_mut     = (gen_reg != '1);
    assign started_ok  = (trial_reg == abst_pkg::TRIAL_STARTED)
                         && (pend_reg != abst_pkg::SLOT_NONE) && can_mut;
    assign dg_cond     = (cand_reg != dev_seq) && (cand_reg < inst_reg);
    assign slot_run_ok = ((cmd.live_slot == abst_pkg::SLOT_A)
                          || (cmd.live_slot == abst_pkg::SLOT_B))
                         && (active_reg == cmd.live_slot);

    always_comb
    begin
        active_next   = active_reg;
        prev_next     = prev_reg;
        pend_next     = pend_reg;
        trial_next    = trial_reg;
        dg_next       = dg_reg;
        gen_next      = gen_reg;
        inst_next     = inst_reg;
        prev_seq_next = prev_seq_reg;
        cand_next     = cand_reg;
        res           = '0;

        unique case (cmd.opcode)
            abst_pkg::OP_BOOT:
            begin
                res.ok = 1'b1;
                priority if (cmd.rescue_held && prev_reg != abst_pkg::SLOT_NONE)
                begin
                    res.boot_action = abst_pkg::ACT_PREVIOUS;
                    res.boot_slot   = prev_reg;
                end
                else if (trial_reg == abst_pkg::TRIAL_STARTED)
                begin
                    res.boot_action = abst_pkg::ACT_RECOVERY;
                    res.boot_slot   = active_reg;
                end
                else if (trial_reg == abst_pkg::TRIAL_PENDING && cmd.pending_verified)
                begin
                    res.boot_action = abst_pkg::ACT_TRIAL;
                    res.boot_slot   = pend_reg;
                end
                else if (trial_reg == abst_pkg::TRIAL_PENDING)
                begin
                    res.boot_action = abst_pkg::ACT_RECOVERY;
                    res.boot_slot   = active_reg;
                end
                else
                begin
                    res.boot_action = abst_pkg::ACT_ACTIVE;
                    res.boot_slot   = active_reg;
                end
            end
            abst_pkg::OP_START:
            begin
                if (trial_reg == abst_pkg::TRIAL_PENDING
                    && pend_reg != abst_pkg::SLOT_NONE && can_mut)
                begin
                    gen_next   = gen_reg + 1'b1;
                    trial_next = abst_pkg::TRIAL_STARTED;
                    dg_next    = 1'b0;
                    res.ok     = 1'b1;
                end
            end
            abst_pkg::OP_RETRY:
            begin
                if (started_ok)
                begin
                    gen_next   = gen_reg + 1'b1;
                    trial_next = abst_pkg::TRIAL_PENDING;
                    dg_next    = dg_cond;
                    res.ok     = 1'b1;
                end
            end
            abst_pkg::OP_DISCARD:
            begin
                if (pend_reg != abst_pkg::SLOT_NONE && can_mut)
                begin
                    gen_next   = gen_reg + 1'b1;
                    pend_next  = abst_pkg::SLOT_NONE;
                    trial_next = abst_pkg::TRIAL_NONE;
                    cand_next  = '0;
                    dg_next    = 1'b0;
                    res.ok     = 1'b1;
                end
            end
            abst_pkg::OP_CONFIRM:
            begin
                if (started_ok)
                begin
                    gen_next      = gen_reg + 1'b1;
                    active_next   = pend_reg;
                    // developer builds leave the floor alone
                    if (cand_reg != dev_seq)
                    begin
                        inst_next = cand_reg;
                    end
                    prev_next     = active_reg;
                    prev_seq_next = inst_reg;
                    pend_next     = abst_pkg::SLOT_NONE;
                    trial_next    = abst_pkg::TRIAL_NONE;
                    cand_next     = '0;
                    dg_next       = 1'b0;
                    res.ok        = 1'b1;
                end
            end
            abst_pkg::OP_RAISE:
            begin
                if (slot_run_ok && trial_reg == abst_pkg::TRIAL_NONE
                    && pend_reg == abst_pkg::SLOT_NONE
                    && cmd.live_seq > inst_reg && can_mut)
                begin
                    gen_next  = gen_reg + 1'b1;
                    inst_next = cmd.live_seq;
                    res.ok    = 1'b1;
                end
            end
            abst_pkg::OP_LOAD:
            begin
                res.ok = 1'b1;
                unique case (cmd.field_index)
                    abst_pkg::FLD_ACTIVE:     active_next   = cmd.field_value[1:0];
                    abst_pkg::FLD_PREVIOUS:   prev_next     = cmd.field_value[1:0];
                    abst_pkg::FLD_PENDING:    pend_next     = cmd.field_value[1:0];
                    abst_pkg::FLD_TRIAL:      trial_next    = cmd.field_value[1:0];
                    abst_pkg::FLD_DOWNGRADE:  dg_next       = cmd.field_value[0];
                    abst_pkg::FLD_GENERATION: gen_next      = cmd.field_value;
                    abst_pkg::FLD_INSTALLED:  inst_next     = cmd.field_value;
                    abst_pkg::FLD_PREV_SEQ:   prev_seq_next = cmd.field_value;
                    abst_pkg::FLD_CANDIDATE:  cand_next     = cmd.field_value;
                    default:                  res.ok        = 1'b0;
                endcase
            end
            default:
            begin
            end
        endcase

        // consistency of the journal as it stands after the command
        res.journal_consistent =
            ((active_next == abst_pkg::SLOT_A) || (active_next == abst_pkg::SLOT_B))
            && (prev_next <= abst_pkg::SLOT_B) && (pend_next <= abst_pkg::SLOT_B)
            && (trial_next <= abst_pkg::TRIAL_STARTED)
            && ((pend_next == abst_pkg::SLOT_NONE) == (trial_next == abst_pkg::TRIAL_NONE))
            && (!dg_next || ((pend_next != abst_pkg::SLOT_NONE)
                             && (cand_next != dev_seq) && (cand_next < inst_next)));

        res.active_now     = active_next;
        res.pending_now    = pend_next;
        res.trial_now      = trial_next;
        res.downgrade_now  = dg_next;
        res.generation_now = gen_next;
        res.floor_now      = inst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= abst_pkg::SLOT_A;
            prev_reg     <= abst_pkg::SLOT_NONE;
            pend_reg     <= abst_pkg::SLOT_NONE;
            trial_reg    <= abst_pkg::TRIAL_NONE;
            dg_reg       <= 1'b0;
            gen_reg      <= '0;
            inst_reg     <= '0;
            prev_seq_reg <= '0;
            cand_reg     <= '0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            prev_reg     <= prev_next;
            pend_reg     <= pend_next;
            trial_reg    <= trial_next;
            dg_reg       <= dg_next;
            gen_reg      <= gen_next;
            inst_reg     <= inst_next;
            prev_seq_reg <= prev_seq_next;
            cand_reg     <= cand_next;
        end
    end

    // check helpers
    logic                         nl_fire;    // anything but a load retires
    logic                         sat_fire;   // same, with the counter saturated
    logic                         ok_fire;    // a mutating command succeeds
    logic [2*abst_pkg::SEQ_W+3:0] key_state;

    assign nl_fire   = fire && (cmd.opcode != abst_pkg::OP_LOAD);
    assign sat_fire  = nl_fire && !can_mut;
    assign ok_fire   = nl_fire && res.ok && (cmd.opcode != abst_pkg::OP_BOOT);
    assign key_state = {gen_reg, inst_reg, active_reg, pend_reg};

    // generation only ever steps by one, except through a load
    `AB_ASSERT(a_gen_step, clk, rst_n, nl_fire |=> (gen_reg - $past(gen_reg) <= 64'd1))
    // a saturated counter freezes the journal for every mutating command
    `AB_ASSERT(a_sat_frozen, clk, rst_n, sat_fire |=> $stable(key_state))
    // a successful mutating command always moves the generation
    `AB_ASSERT(a_ok_bumps, clk, rst_n, ok_fire |=> (gen_reg - $past(gen_reg) == 64'd1))

endmodule

>>> rtl/ab_boot_slot_trial_controller.sv
`include "assert_macros.svh"

// A/B boot slot journal controller. Each command transaction (boot decision,
// start/retry/discard/confirm trial, raise anti-rollback floor, or load of one
// journal field) yields exactly one result transaction carrying success, the
// boot action and slot, a journal consistency flag and a read-back of the key
// journal fields after the command. Throughput is one command per clock while
// the result consumer keeps ready high. The result is registered: a command
// passes the command register, then the combinational journal update, into
// the result register, from which the result is presented. The command and
// result stages stall together when the result consumer holds off ready; a
// new command is still taken into an empty command stage while a finished
// result waits. The developer_sequence register resets to all ones and is
// written through the cfg channel, which is always ready; write it only
// while no command is in flight.
module ab_boot_slot_trial_controller (
    input  logic       clk,
    input  logic       rst_n,
    abst_cmd_if.sink   cmd,
    abst_res_if.source res,
    abst_cfg_if.sink   cfg
);

    // developer build marker
    abst_pkg::seq_t dev_seq_reg;

    // command stage
    logic           stg_valid_reg;
    abst_pkg::cmd_t stg_cmd_reg;

    // result stage
    logic           out_valid_reg;
    abst_pkg::res_t out_res_reg;

    abst_pkg::res_t step_res;
    logic           advance;    // result stage can take a new transaction
    logic           fire;       // command stage retires into the result stage

    assign advance   = !out_valid_reg || res.ready;
    assign fire      = stg_valid_reg && advance;
    assign cmd.ready = !stg_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_seq_reg <= '1;
        end
        else if (cfg.valid)
        begin
            dev_seq_reg <= cfg.data;
        end
    end

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            stg_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            stg_cmd_reg.opcode           <= abst_pkg::op_t'(cmd.opcode);
            stg_cmd_reg.rescue_held      <= cmd.rescue_held;
            stg_cmd_reg.pending_verified <= cmd.pending_verified;
            stg_cmd_reg.live_slot        <= cmd.live_slot;
            stg_cmd_reg.live_seq         <= cmd.live_seq;
            stg_cmd_reg.field_index      <= cmd.field_index;
            stg_cmd_reg.field_value      <= cmd.field_value;
        end
    end

    abst_journal u_journal (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .cmd     (stg_cmd_reg),
        .dev_seq (dev_seq_reg),
        .res     (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.ok                 = out_res_reg.ok;
    assign res.boot_action        = out_res_reg.boot_action;
    assign res.boot_slot          = out_res_reg.boot_slot;
    assign res.journal_consistent = out_res_reg.journal_consistent;
    assign res.active_now         = out_res_reg.active_now;
    assign res.pending_now        = out_res_reg.pending_now;
    assign res.trial_now          = out_res_reg.trial_now;
    assign res.downgrade_now      = out_res_reg.downgrade_now;
    assign res.generation_now     = out_res_reg.generation_now;
    assign res.floor_now          = out_res_reg.floor_now;

    // a result only shows up behind a command that was in the stage
    `AB_ASSERT(a_res_source, clk, rst_n, $rose(out_valid_reg) |-> $past(stg_valid_reg))
    // a held command stays in the stage while the result side stalls
    `AB_ASSERT(a_stage_hold, clk, rst_n, (stg_valid_reg && !advance) |=> stg_valid_reg)
    // taking a command into a full stage requires the stage to retire
    `AB_ASSERT(a_no_overrun, clk, rst_n, (cmd.valid && cmd.ready && stg_valid_reg) |-> fire)

endmodule
